FILE: design/fcj_pkg.sv
`timescale 1ns / 1ps

package fcj_pkg;

    localparam int COORD_W      = 16;
    localparam int SEG_W        = COORD_W + 1;
    localparam int MAX_SEG      = 3;
    localparam int AFB          = 8;
    localparam int ACC_FRAC     = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int ROOT_STEPS   = 32;
    localparam int PROD_LIM_BIT = 30;

    localparam int MUL_W    = 31;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 36;
    localparam int CROSS_W  = 34;
    localparam int DOT_W    = 35;
    localparam int SQ_W     = 64;
    localparam int ROT_W    = 36;
    localparam int Z_W      = 26;
    localparam int ANG_W    = 8 + AFB;
    localparam int BEND_W   = ANG_W + 2;
    localparam int FULL_W   = 10;
    localparam int NUM_W    = BEND_W + ACC_FRAC - AFB;
    localparam int STEP_W   = 6;
    localparam int REG_W    = 8;
    localparam int NREG     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int FINGER_W = 3;
    localparam int CURL_W   = 16;
    localparam int CNT_W    = 3;

    localparam int ANGLE_SHIFT = ACC_FRAC - AFB;
    localparam int ANGLE_ROUND = (1 << ANGLE_SHIFT) >> 1;

    localparam int MUL_LAST = 9;
    localparam int SQR_LAST = 3;

    localparam logic [CFG_IDX_W-1:0] REG_THUMB0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT0 = 3'd3;

    typedef struct packed {
        logic              accept;
        logic              first;
        logic              mul;
        logic              norm;
        logic              sqr;
        logic              root;
        logic              rot;
        logic              upd;
        logic              div;
        logic              load;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic angle_due;
        logic zero;
        logic big;
    } stat_t;

    function automatic logic [REG_W-1:0] cfg_reset(input logic [CFG_IDX_W-1:0] idx);
        logic [REG_W-1:0] v;
        unique case (idx)
            3'd0:    v = 8'd60;
            3'd1:    v = 8'd60;
            3'd2:    v = 8'd80;
            3'd3:    v = 8'd90;
            3'd4:    v = 8'd100;
            3'd5:    v = 8'd80;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [Z_W-1:0] atan_val(input logic [4:0] i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            5'd0:    v = Z_W'(2949120);
            5'd1:    v = Z_W'(1740967);
            5'd2:    v = Z_W'(919879);
            5'd3:    v = Z_W'(466945);
            5'd4:    v = Z_W'(234379);
            5'd5:    v = Z_W'(117304);
            5'd6:    v = Z_W'(58666);
            5'd7:    v = Z_W'(29335);
            5'd8:    v = Z_W'(14668);
            5'd9:    v = Z_W'(7334);
            5'd10:   v = Z_W'(3667);
            5'd11:   v = Z_W'(1833);
            5'd12:   v = Z_W'(917);
            5'd13:   v = Z_W'(458);
            5'd14:   v = Z_W'(229);
            5'd15:   v = Z_W'(115);
            5'd16:   v = Z_W'(57);
            5'd17:   v = Z_W'(29);
            5'd18:   v = Z_W'(14);
            5'd19:   v = Z_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

    // shift of the magnitude, sign kept
    function automatic logic signed [ROT_W-1:0] shr_sym(input logic signed [ROT_W-1:0] v,
                                                        input logic [4:0] s);
        logic [ROT_W-1:0] m;
        m = v[ROT_W-1] ? $unsigned(-v) : $unsigned(v);
        m = m >> s;
        return v[ROT_W-1] ? -$signed(m) : $signed(m);
    endfunction

endpackage

FILE: design/fcj_ctrl.sv
`timescale 1ns / 1ps

module fcj_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            first_of_chain,
    input  logic            last_of_chain,
    output logic            out_valid,
    input  logic            out_stall,
    input  fcj_pkg::stat_t  stat,
    output fcj_pkg::cmd_t   cmd
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_NORM = 9'b000000100,
        S_SQR  = 9'b000001000,
        S_ROOT = 9'b000010000,
        S_ROT  = 9'b000100000,
        S_UPD  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_EMIT = 9'b100000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [fcj_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        last_reg, last_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        accept;
    logic                        load;

    assign accept = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg + fcj_pkg::STEP_W'(1);
        load       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    if (first_of_chain)
                        state_next = last_of_chain ? S_EMIT : S_IDLE;
                    else
                        state_next = stat.angle_due ? S_MUL : S_UPD;
                end
            end
            S_MUL:
            begin
                if (step_reg == fcj_pkg::STEP_W'(fcj_pkg::MUL_LAST))
                begin
                    state_next = S_NORM;
                    step_next  = '0;
                end
            end
            S_NORM:
            begin
                step_next = '0;
                if (stat.zero)
                    state_next = S_UPD;
                else if (!stat.big)
                    state_next = S_SQR;
            end
            S_SQR:
            begin
                if (step_reg == fcj_pkg::STEP_W'(fcj_pkg::SQR_LAST))
                begin
                    state_next = S_ROOT;
                    step_next  = '0;
                end
            end
            S_ROOT:
            begin
                if (step_reg == fcj_pkg::STEP_W'(fcj_pkg::ROOT_STEPS - 1))
                begin
                    state_next = S_ROT;
                    step_next  = '0;
                end
            end
            S_ROT:
            begin
                if (step_reg == fcj_pkg::STEP_W'(fcj_pkg::CORDIC_STEPS))
                begin
                    state_next = S_UPD;
                    step_next  = '0;
                end
            end
            S_UPD:
            begin
                step_next  = '0;
                state_next = last_reg ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (step_reg == fcj_pkg::STEP_W'(fcj_pkg::NUM_W))
                begin
                    state_next = S_EMIT;
                    step_next  = '0;
                end
            end
            S_EMIT:
            begin
                step_next = '0;
                if (!out_valid_reg || !out_stall)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                step_next  = '0;
            end
        endcase
    end

    assign last_next      = accept ? last_of_chain : last_reg;
    assign out_valid_next = load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.accept = accept;
        cmd.first  = first_of_chain;
        cmd.mul    = (state_reg == S_MUL);
        cmd.norm   = (state_reg == S_NORM);
        cmd.sqr    = (state_reg == S_SQR);
        cmd.root   = (state_reg == S_ROOT);
        cmd.rot    = (state_reg == S_ROT);
        cmd.upd    = (state_reg == S_UPD);
        cmd.div    = (state_reg == S_DIV);
        cmd.load   = load;
        cmd.step   = step_reg;
    end

endmodule

FILE: design/fcj_dp.sv
`timescale 1ns / 1ps

module fcj_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fcj_pkg::cmd_t                         cmd,
    output fcj_pkg::stat_t                        stat,
    input  logic                                  cfg_valid,
    input  logic [fcj_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fcj_pkg::REG_W-1:0]             cfg_data,
    input  logic [fcj_pkg::FINGER_W-1:0]          finger_index,
    input  logic signed [fcj_pkg::COORD_W-1:0]    point_x,
    input  logic signed [fcj_pkg::COORD_W-1:0]    point_y,
    input  logic signed [fcj_pkg::COORD_W-1:0]    point_z,
    output logic [fcj_pkg::FINGER_W-1:0]          curl_finger,
    output logic [fcj_pkg::CURL_W-1:0]            curl,
    output logic                                  chain_valid
);

    localparam int CW = fcj_pkg::COORD_W;
    localparam int SW = fcj_pkg::SEG_W;

    logic [fcj_pkg::REG_W-1:0]        cfg_reg [fcj_pkg::NREG];
    logic signed [CW-1:0]             last_point_reg [3];
    logic signed [SW-1:0]             last_seg_reg [3];
    logic [fcj_pkg::CNT_W-1:0]        joint_count_reg;
    logic [fcj_pkg::BEND_W-1:0]       bend_sum_reg;
    logic [fcj_pkg::FULL_W-1:0]       full_sum_reg;
    logic [fcj_pkg::FINGER_W-1:0]     chain_finger_reg;

    logic signed [SW-1:0]             seg_reg [3];
    logic signed [fcj_pkg::PROD_W-1:0] prod_reg;
    logic signed [fcj_pkg::ACC_W-1:0] acc_reg;
    logic [fcj_pkg::CROSS_W-1:0]      cross_reg [3];
    logic signed [fcj_pkg::DOT_W-1:0] dot_reg;
    logic [fcj_pkg::SQ_W-1:0]         sumsq_reg;
    logic [fcj_pkg::SQ_W-1:0]         n_reg;
    logic [fcj_pkg::SQ_W-1:0]         r_reg;
    logic [fcj_pkg::SQ_W-1:0]         bit_reg;
    logic signed [fcj_pkg::ROT_W-1:0] x_reg;
    logic signed [fcj_pkg::ROT_W-1:0] y_reg;
    logic signed [fcj_pkg::Z_W-1:0]   z_reg;
    logic [fcj_pkg::NUM_W-1:0]        quo_reg;
    logic [fcj_pkg::FULL_W-1:0]       rem_reg;
    logic                             zero_reg;
    logic                             due_reg;
    logic [fcj_pkg::FINGER_W-1:0]     curl_finger_reg;
    logic [fcj_pkg::CURL_W-1:0]       curl_reg;
    logic                             chain_valid_reg;

    logic signed [CW-1:0]             pt [3];
    logic signed [fcj_pkg::MUL_W-1:0] mul_a, mul_b;
    logic signed [fcj_pkg::ACC_W-1:0] prod_s;
    logic signed [fcj_pkg::ACC_W-1:0] diff;
    logic [fcj_pkg::CROSS_W-1:0]      diff_mag;
    logic [fcj_pkg::DOT_W-1:0]        dot_mag;
    logic [fcj_pkg::SQ_W-1:0]         prod_u;
    logic [fcj_pkg::SQ_W-1:0]         root_try;
    logic [4:0]                       rot_i;
    logic signed [fcj_pkg::ROT_W-1:0] sx, sy;
    logic signed [fcj_pkg::ROT_W-1:0] dot_ext;
    logic signed [fcj_pkg::Z_W-1:0]   z_clamp;
    logic signed [fcj_pkg::Z_W-1:0]   z_round;
    logic [fcj_pkg::ANG_W-1:0]        angle;
    logic [fcj_pkg::CFG_IDX_W-1:0]    cfg_sel;
    logic [fcj_pkg::FULL_W:0]         rem_sh;
    logic                             rem_ge;
    logic                             valid_now;
    logic [fcj_pkg::CURL_W-1:0]       curl_now;

    localparam logic signed [fcj_pkg::Z_W-1:0] Z_180 =
        fcj_pkg::Z_W'(180 << fcj_pkg::ACC_FRAC);
    localparam logic signed [fcj_pkg::Z_W-1:0] Z_90 =
        fcj_pkg::Z_W'(90 << fcj_pkg::ACC_FRAC);
    localparam logic [fcj_pkg::ANG_W-1:0] ANG_90 =
        fcj_pkg::ANG_W'(90 << fcj_pkg::AFB);
    localparam logic [fcj_pkg::SQ_W-1:0] ROOT_TOP =
        {2'b01, {(fcj_pkg::SQ_W - 2){1'b0}}};

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    assign stat.angle_due = (joint_count_reg >= fcj_pkg::CNT_W'(1)) &&
                            (joint_count_reg <= fcj_pkg::CNT_W'(fcj_pkg::MAX_SEG));
    assign stat.zero = (cross_reg[0] == '0) && (cross_reg[1] == '0) &&
                       (cross_reg[2] == '0) && (dot_reg == '0);
    assign dot_mag   = dot_reg[fcj_pkg::DOT_W-1] ? $unsigned(-dot_reg) : $unsigned(dot_reg);
    assign stat.big  = (cross_reg[0] >= fcj_pkg::CROSS_W'(64'd1 << fcj_pkg::PROD_LIM_BIT)) ||
                       (cross_reg[1] >= fcj_pkg::CROSS_W'(64'd1 << fcj_pkg::PROD_LIM_BIT)) ||
                       (cross_reg[2] >= fcj_pkg::CROSS_W'(64'd1 << fcj_pkg::PROD_LIM_BIT)) ||
                       (dot_mag >= fcj_pkg::DOT_W'(64'd1 << fcj_pkg::PROD_LIM_BIT));

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.mul)
        begin
            unique case (cmd.step)
                6'd0:    begin mul_a = fcj_pkg::MUL_W'(last_seg_reg[1]); mul_b = fcj_pkg::MUL_W'(seg_reg[2]); end
                6'd1:    begin mul_a = fcj_pkg::MUL_W'(last_seg_reg[2]); mul_b = fcj_pkg::MUL_W'(seg_reg[1]); end
                6'd2:    begin mul_a = fcj_pkg::MUL_W'(last_seg_reg[2]); mul_b = fcj_pkg::MUL_W'(seg_reg[0]); end
                6'd3:    begin mul_a = fcj_pkg::MUL_W'(last_seg_reg[0]); mul_b = fcj_pkg::MUL_W'(seg_reg[2]); end
                6'd4:    begin mul_a = fcj_pkg::MUL_W'(last_seg_reg[0]); mul_b = fcj_pkg::MUL_W'(seg_reg[1]); end
                6'd5:    begin mul_a = fcj_pkg::MUL_W'(last_seg_reg[1]); mul_b = fcj_pkg::MUL_W'(seg_reg[0]); end
                6'd6:    begin mul_a = fcj_pkg::MUL_W'(last_seg_reg[0]); mul_b = fcj_pkg::MUL_W'(seg_reg[0]); end
                6'd7:    begin mul_a = fcj_pkg::MUL_W'(last_seg_reg[1]); mul_b = fcj_pkg::MUL_W'(seg_reg[1]); end
                6'd8:    begin mul_a = fcj_pkg::MUL_W'(last_seg_reg[2]); mul_b = fcj_pkg::MUL_W'(seg_reg[2]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (cmd.sqr)
        begin
            unique case (cmd.step)
                6'd0:    mul_a = $signed({1'b0, cross_reg[0][fcj_pkg::MUL_W-2:0]});
                6'd1:    mul_a = $signed({1'b0, cross_reg[1][fcj_pkg::MUL_W-2:0]});
                6'd2:    mul_a = $signed({1'b0, cross_reg[2][fcj_pkg::MUL_W-2:0]});
                default: mul_a = '0;
            endcase
            mul_b = mul_a;
        end
    end

    assign prod_s   = $signed(prod_reg[fcj_pkg::ACC_W-1:0]);
    assign diff     = acc_reg - prod_s;
    assign diff_mag = diff[fcj_pkg::ACC_W-1] ? fcj_pkg::CROSS_W'($unsigned(-diff))
                                              : fcj_pkg::CROSS_W'($unsigned(diff));
    assign prod_u   = fcj_pkg::SQ_W'($unsigned(prod_reg));
    assign root_try = r_reg + bit_reg;

    assign rot_i   = 5'(cmd.step - fcj_pkg::STEP_W'(1));
    assign sx      = fcj_pkg::shr_sym(x_reg, rot_i);
    assign sy      = fcj_pkg::shr_sym(y_reg, rot_i);
    assign dot_ext = fcj_pkg::ROT_W'(dot_reg);

    assign z_clamp = (z_reg < 0) ? '0 : ((z_reg > Z_180) ? Z_180 : z_reg);
    assign z_round = z_clamp + fcj_pkg::Z_W'(fcj_pkg::ANGLE_ROUND);
    assign angle   = zero_reg ? ANG_90
                              : fcj_pkg::ANG_W'($unsigned(z_round) >> fcj_pkg::ANGLE_SHIFT);
    assign cfg_sel = ((chain_finger_reg == '0) ? fcj_pkg::REG_THUMB0 : fcj_pkg::REG_DIGIT0) +
                     fcj_pkg::CFG_IDX_W'(joint_count_reg - fcj_pkg::CNT_W'(1));

    assign rem_sh = {rem_reg, quo_reg[fcj_pkg::NUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, full_sum_reg});

    assign valid_now = (joint_count_reg >= fcj_pkg::CNT_W'(2));
    always_comb
    begin
        if (!valid_now)
            curl_now = '0;
        else if (full_sum_reg == '0)
            curl_now = (bend_sum_reg != '0) ? '1 : '0;
        else if (quo_reg[fcj_pkg::NUM_W-1:fcj_pkg::CURL_W] != '0)
            curl_now = '1;
        else
            curl_now = quo_reg[fcj_pkg::CURL_W-1:0];
    end

    // chain state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fcj_pkg::NREG; i++)
                cfg_reg[i] <= fcj_pkg::cfg_reset(fcj_pkg::CFG_IDX_W'(i));
            for (int i = 0; i < 3; i++)
            begin
                last_point_reg[i] <= '0;
                last_seg_reg[i]   <= '0;
            end
            joint_count_reg  <= '0;
            bend_sum_reg     <= '0;
            full_sum_reg     <= '0;
            chain_finger_reg <= '0;
        end
        else
        begin
            if (cfg_valid && (cfg_index < fcj_pkg::CFG_IDX_W'(fcj_pkg::NREG)))
                cfg_reg[cfg_index] <= cfg_data;
            if (cmd.accept)
            begin
                for (int i = 0; i < 3; i++)
                    last_point_reg[i] <= pt[i];
                if (cmd.first)
                begin
                    chain_finger_reg <= finger_index;
                    joint_count_reg  <= '0;
                    bend_sum_reg     <= '0;
                    full_sum_reg     <= '0;
                end
            end
            if (cmd.upd)
            begin
                if (due_reg)
                begin
                    bend_sum_reg <= bend_sum_reg + fcj_pkg::BEND_W'(angle);
                    full_sum_reg <= full_sum_reg + fcj_pkg::FULL_W'(cfg_reg[cfg_sel]);
                end
                for (int i = 0; i < 3; i++)
                    last_seg_reg[i] <= seg_reg[i];
                if (joint_count_reg != '1)
                    joint_count_reg <= joint_count_reg + fcj_pkg::CNT_W'(1);
            end
            if (cmd.load)
            begin
                joint_count_reg <= '0;
                bend_sum_reg    <= '0;
                full_sum_reg    <= '0;
            end
        end
    end

    // arithmetic pipeline
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (cmd.accept)
        begin
            for (int i = 0; i < 3; i++)
                seg_reg[i] <= SW'(pt[i]) - SW'(last_point_reg[i]);
            due_reg  <= stat.angle_due;
            zero_reg <= 1'b0;
        end

        if (cmd.mul)
        begin
            unique case (cmd.step)
                6'd1, 6'd3, 6'd5, 6'd7: acc_reg <= prod_s;
                6'd2:    cross_reg[0] <= diff_mag;
                6'd4:    cross_reg[1] <= diff_mag;
                6'd6:    cross_reg[2] <= diff_mag;
                6'd8:    acc_reg <= acc_reg + prod_s;
                6'd9:    dot_reg <= fcj_pkg::DOT_W'(acc_reg + prod_s);
                default: acc_reg <= acc_reg;
            endcase
        end

        if (cmd.norm)
        begin
            if (stat.zero)
                zero_reg <= 1'b1;
            else if (stat.big)
            begin
                for (int i = 0; i < 3; i++)
                    cross_reg[i] <= cross_reg[i] >> 1;
                dot_reg <= fcj_pkg::DOT_W'(fcj_pkg::shr_sym(dot_ext, 5'd1));
            end
        end

        if (cmd.sqr)
        begin
            unique case (cmd.step)
                6'd1:    sumsq_reg <= prod_u;
                6'd2:    sumsq_reg <= sumsq_reg + prod_u;
                6'd3:
                begin
                    n_reg   <= sumsq_reg + prod_u;
                    r_reg   <= '0;
                    bit_reg <= ROOT_TOP;
                end
                default: sumsq_reg <= sumsq_reg;
            endcase
        end

        if (cmd.root)
        begin
            if (n_reg >= root_try)
            begin
                n_reg <= n_reg - root_try;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
                r_reg <= r_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end

        if (cmd.rot)
        begin
            if (cmd.step == '0)
            begin
                if (dot_reg < 0)
                begin
                    x_reg <= $signed(r_reg[fcj_pkg::ROT_W-1:0]);
                    y_reg <= -dot_ext;
                    z_reg <= Z_90;
                end
                else
                begin
                    x_reg <= dot_ext;
                    y_reg <= $signed(r_reg[fcj_pkg::ROT_W-1:0]);
                    z_reg <= '0;
                end
            end
            else if (y_reg > 0)
            begin
                x_reg <= x_reg + sy;
                y_reg <= y_reg - sx;
                z_reg <= z_reg + fcj_pkg::atan_val(rot_i);
            end
            else
            begin
                x_reg <= x_reg - sy;
                y_reg <= y_reg + sx;
                z_reg <= z_reg - fcj_pkg::atan_val(rot_i);
            end
        end

        if (cmd.div)
        begin
            if (cmd.step == '0)
            begin
                quo_reg <= fcj_pkg::NUM_W'(bend_sum_reg) << fcj_pkg::ANGLE_SHIFT;
                rem_reg <= '0;
            end
            else
            begin
                rem_reg <= rem_ge ? fcj_pkg::FULL_W'(rem_sh - {1'b0, full_sum_reg})
                                  : rem_sh[fcj_pkg::FULL_W-1:0];
                quo_reg <= {quo_reg[fcj_pkg::NUM_W-2:0], rem_ge};
            end
        end

        if (cmd.load)
        begin
            curl_finger_reg <= chain_finger_reg;
            curl_reg        <= curl_now;
            chain_valid_reg <= valid_now;
        end
    end

    assign curl_finger = curl_finger_reg;
    assign curl        = curl_reg;
    assign chain_valid = chain_valid_reg;

endmodule

FILE: design/finger_curl_from_joints_unit.sv
`timescale 1ns / 1ps

// Finger curl from a chain of 3-D joint points.
// Input channel (in_valid/in_stall): one point per beat, a wrist point with
// first_of_chain set, then joint points knuckle outward, the last one with
// last_of_chain set. Output channel (out_valid/out_stall): one beat per chain
// carrying curl_finger, curl (Q0.16) and chain_valid.
// Config port (cfg_valid/cfg_ready/cfg_index/cfg_data): bend limit table,
// always ready; write it only while the block is idle.
// Work per point: a wrist point starts the chain; a joint with no bend term
// only updates it; a joint with a bend term runs multiply and normalize, then,
// unless cross and dot products are all zero, square, root and CORDIC, then
// update, all set by the single shared multiplier, the bit-serial root and the
// CORDIC loop. The last joint point adds restoring division and an output load.
// in_stall is high while a point is in work. A finished result sits in the
// output register; a new point is accepted while it waits, and the block only
// holds in its final step if the next result is ready before that beat leaves.
// Reset clears the chain state and loads the default bend limits.

module finger_curl_from_joints_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [fcj_pkg::FINGER_W-1:0]          finger_index,
    input  logic signed [fcj_pkg::COORD_W-1:0]    point_x,
    input  logic signed [fcj_pkg::COORD_W-1:0]    point_y,
    input  logic signed [fcj_pkg::COORD_W-1:0]    point_z,
    input  logic                                  first_of_chain,
    input  logic                                  last_of_chain,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [fcj_pkg::FINGER_W-1:0]          curl_finger,
    output logic [fcj_pkg::CURL_W-1:0]            curl,
    output logic                                  chain_valid,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fcj_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fcj_pkg::REG_W-1:0]             cfg_data
);

    fcj_pkg::cmd_t  cmd;
    fcj_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    fcj_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_of_chain (first_of_chain),
        .last_of_chain  (last_of_chain),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .stat           (stat),
        .cmd            (cmd)
    );

    fcj_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .finger_index (finger_index),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .curl_finger  (curl_finger),
        .curl         (curl),
        .chain_valid  (chain_valid)
    );

endmodule

FILE: design/fcj_checker.sv
`timescale 1ns / 1ps

module fcj_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic                                  first_of_chain,
    input logic                                  last_of_chain,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic [fcj_pkg::CURL_W-1:0]            curl,
    input logic                                  chain_valid
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(curl) && $stable(chain_valid))
        else $error("out payload changed while stalled");

    a_short_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !chain_valid |-> curl == '0)
        else $error("short chain with nonzero curl");

    a_busy_after_joint: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (last_of_chain || !first_of_chain) |=> in_stall)
        else $error("joint or last point not held busy");

endmodule

bind finger_curl_from_joints_unit fcj_checker u_fcj_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .first_of_chain (first_of_chain),
    .last_of_chain  (last_of_chain),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .curl           (curl),
    .chain_valid    (chain_valid)
);
